>>> rtl/mwfa_pkg.sv
// ---------------------------------------------------------------------------
// Word field ALU package
// Shared widths, command codes, item types and byte helpers for the
// sign-magnitude word field ALU.
// ---------------------------------------------------------------------------
package mwfa_pkg;

  // Word layout: five 6-bit bytes, byte 1 most significant.
  localparam int unsigned BYTE_W    = 6;
  localparam int unsigned NUM_BYTES = 5;
  localparam int unsigned MAG_W     = NUM_BYTES * BYTE_W;
  localparam int unsigned FIELD_W   = 3;
  localparam int unsigned CMD_W     = 2;

  // Highest legal field index.
  localparam logic [FIELD_W-1:0] MAX_FIELD = FIELD_W'(NUM_BYTES);

  // Bytes 1 to 3 sit above this bit; any of them set flags an index overflow.
  localparam int unsigned INDEX_LSB = (NUM_BYTES - 3) * BYTE_W;

  // Command codes. The last code passes the destination word through.
  typedef enum logic [CMD_W-1:0] {
    CMD_MERGE  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_NEGATE = 2'd2,
    CMD_PASS   = 2'd3
  } cmd_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic               dest_sign;
    logic [MAG_W-1:0]   dest_mag;
    logic               dest_ov;
    logic               src_sign;
    logic [MAG_W-1:0]   src_mag;
    logic               src_ov;
    logic [FIELD_W-1:0] field_left;
    logic [FIELD_W-1:0] field_right;
    logic               clear_sign;
    logic               align_from_source;
    logic               align_to_dest_right;
  } in_item_t;

  // Result of one datapath unit.
  typedef struct packed {
    logic             sign;
    logic [MAG_W-1:0] mag;
    logic             ov;
    logic             bad;
  } unit_res_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic             result_sign;
    logic [MAG_W-1:0] result_mag;
    logic             result_ov;
    logic             index_overflow;
    logic             bad_field;
  } out_item_t;

  // Fetch byte idx (1..5) of a magnitude; other indexes give zero.
  function automatic logic [BYTE_W-1:0] get_byte(input logic [MAG_W-1:0]   mag,
                                                 input logic [FIELD_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    for (int unsigned i = 1; i <= NUM_BYTES; i++) begin
      if (idx == FIELD_W'(i)) begin
        b = mag[BYTE_W*(NUM_BYTES-i) +: BYTE_W];
      end
    end
    return b;
  endfunction

endpackage

>>> rtl/mwfa_if.sv
// ---------------------------------------------------------------------------
// Word field ALU channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------

// Command channel: one operation with its operands and field controls.
interface mwfa_in_if import mwfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic               dest_sign;
  logic [MAG_W-1:0]   dest_mag;
  logic               dest_ov;
  logic               src_sign;
  logic [MAG_W-1:0]   src_mag;
  logic               src_ov;
  logic [FIELD_W-1:0] field_left;
  logic [FIELD_W-1:0] field_right;
  logic               clear_sign;
  logic               align_from_source;
  logic               align_to_dest_right;

  modport source (
    output valid, command, dest_sign, dest_mag, dest_ov, src_sign, src_mag, src_ov,
           field_left, field_right, clear_sign, align_from_source,
           align_to_dest_right,
    input  ready
  );

  modport sink (
    input  valid, command, dest_sign, dest_mag, dest_ov, src_sign, src_mag, src_ov,
           field_left, field_right, clear_sign, align_from_source,
           align_to_dest_right,
    output ready
  );
endinterface

// Result channel: one result word with its flags.
interface mwfa_out_if import mwfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_sign;
  logic [MAG_W-1:0] result_mag;
  logic             result_ov;
  logic             index_overflow;
  logic             bad_field;

  modport source (
    output valid, result_sign, result_mag, result_ov, index_overflow, bad_field,
    input  ready
  );

  modport sink (
    input  valid, result_sign, result_mag, result_ov, index_overflow, bad_field,
    output ready
  );
endinterface

>>> rtl/mix_word_field_alu_unit.sv
// ---------------------------------------------------------------------------
// Word field ALU
// Field merge, add and negate on sign-magnitude words of five 6-bit bytes,
// with an input register and a result register around the datapath.
// ---------------------------------------------------------------------------
//
//  Channel  Modport  Direction  Carries
//  cmd_i    sink     in         command, both operands, field controls
//  res_o    source   out        result word, overflow and field flags
//
// Every item passes through the input register and then the result register on
// its way from cmd_i to res_o, and a new item is taken in every cycle while
// res_o is ready. Reset clears the valid bits of both registers only. A stall
// on res_o holds the result register, and cmd_i keeps taking items until the
// input register is also full.
module mix_word_field_alu_unit import mwfa_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  mwfa_in_if.sink    cmd_i,
  mwfa_out_if.source res_o
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_d;
  out_item_t out_q;
  logic      out_valid_q;
  logic      out_ready;
  logic      in_ready;
  unit_res_t merge_res;
  unit_res_t add_res;
  unit_res_t sel_res;

  // Each register takes a new item when it is empty or being drained.
  assign out_ready = !out_valid_q || res_o.ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign cmd_i.ready = in_ready;

  // Valid bits for both registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register payload, loaded on a transfer.
  always_ff @(posedge clk_i) begin
    if (in_ready && cmd_i.valid) begin
      in_q.command             <= cmd_i.command;
      in_q.dest_sign           <= cmd_i.dest_sign;
      in_q.dest_mag            <= cmd_i.dest_mag;
      in_q.dest_ov             <= cmd_i.dest_ov;
      in_q.src_sign            <= cmd_i.src_sign;
      in_q.src_mag             <= cmd_i.src_mag;
      in_q.src_ov              <= cmd_i.src_ov;
      in_q.field_left          <= cmd_i.field_left;
      in_q.field_right         <= cmd_i.field_right;
      in_q.clear_sign          <= cmd_i.clear_sign;
      in_q.align_from_source   <= cmd_i.align_from_source;
      in_q.align_to_dest_right <= cmd_i.align_to_dest_right;
    end
  end

  mwfa_merge u_merge (
    .item_i (in_q),
    .res_o  (merge_res)
  );

  mwfa_add u_add (
    .dest_sign_i (in_q.dest_sign),
    .dest_mag_i  (in_q.dest_mag),
    .src_sign_i  (in_q.src_sign),
    .src_mag_i   (in_q.src_mag),
    .res_o       (add_res)
  );

  // Command select; negate and pass keep the destination magnitude and overflow, negate inverts its sign.
  always_comb begin
    sel_res.sign = in_q.dest_sign;
    sel_res.mag  = in_q.dest_mag;
    sel_res.ov   = in_q.dest_ov;
    sel_res.bad  = 1'b0;
    case (cmd_e'(in_q.command))
      CMD_MERGE:  sel_res = merge_res;
      CMD_ADD:    sel_res = add_res;
      CMD_NEGATE: sel_res.sign = !in_q.dest_sign;
      CMD_PASS:   sel_res.sign = in_q.dest_sign;
      default:    sel_res.sign = in_q.dest_sign;
    endcase
  end

  // Result word with the index overflow flag.
  always_comb begin
    out_d.result_sign    = sel_res.sign;
    out_d.result_mag     = sel_res.mag;
    out_d.result_ov      = sel_res.ov;
    out_d.index_overflow = sel_res.ov || (sel_res.mag[MAG_W-1:INDEX_LSB] != '0);
    out_d.bad_field      = sel_res.bad;
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.result_sign    = out_q.result_sign;
  assign res_o.result_mag     = out_q.result_mag;
  assign res_o.result_ov      = out_q.result_ov;
  assign res_o.index_overflow = out_q.index_overflow;
  assign res_o.bad_field      = out_q.bad_field;

endmodule

>>> rtl/mwfa_merge.sv
// ---------------------------------------------------------------------------
// Word field ALU partial field merge
// Copies source bytes into destination field L..R, in place or aligned
// to the right on either side, and works out the merged sign.
// ---------------------------------------------------------------------------
module mwfa_merge import mwfa_pkg::*; (
  input  in_item_t  item_i,
  output unit_res_t res_o
);

  logic               bad;
  logic [FIELD_W-1:0] lo;
  logic [FIELD_W-1:0] rhs;
  logic [FIELD_W-1:0] shift;
  logic [FIELD_W:0]   lo_shifted;
  logic [MAG_W-1:0]   mag;
  logic               sign;

  // Field checks; a zero left index selects the sign and starts at byte 1.
  assign bad        = (item_i.field_left > MAX_FIELD) || (item_i.field_right > MAX_FIELD);
  assign lo         = (item_i.field_left == '0) ? FIELD_W'(1) : item_i.field_left;
  assign rhs        = item_i.field_right;
  assign shift      = MAX_FIELD - rhs;
  assign lo_shifted = {1'b0, lo} + {1'b0, shift};

  // Sign: forced positive or kept, unless the field includes the sign.
  always_comb begin
    sign = item_i.clear_sign ? 1'b0 : item_i.dest_sign;
    if (item_i.field_left == '0) begin
      sign = item_i.src_sign;
    end
  end

  // Each destination byte picks its source byte independently.
  always_comb begin
    logic [FIELD_W-1:0] j;
    mag = item_i.dest_mag;
    for (int unsigned i = 1; i <= NUM_BYTES; i++) begin
      j = FIELD_W'(i);
      if (!bad) begin
        if (item_i.align_from_source) begin
          if (j >= lo && j <= rhs) begin
            mag[BYTE_W*(NUM_BYTES-i) +: BYTE_W] = get_byte(item_i.src_mag, j + shift);
          end
        end else if (item_i.align_to_dest_right) begin
          if ({1'b0, j} >= lo_shifted) begin
            mag[BYTE_W*(NUM_BYTES-i) +: BYTE_W] = get_byte(item_i.src_mag, j - shift);
          end
        end else begin
          if (j >= lo && j <= rhs) begin
            mag[BYTE_W*(NUM_BYTES-i) +: BYTE_W] = get_byte(item_i.src_mag, j);
          end
        end
      end
    end
  end

  assign res_o.sign = sign;
  assign res_o.mag  = mag;
  assign res_o.ov   = item_i.dest_ov | item_i.src_ov;
  assign res_o.bad  = bad;

endmodule

>>> rtl/mwfa_add.sv
// ---------------------------------------------------------------------------
// Word field ALU adder
// Sign-magnitude add with a wrapping magnitude and carry-out overflow.
// ---------------------------------------------------------------------------
module mwfa_add import mwfa_pkg::*; (
  input  logic             dest_sign_i,
  input  logic [MAG_W-1:0] dest_mag_i,
  input  logic             src_sign_i,
  input  logic [MAG_W-1:0] src_mag_i,
  output unit_res_t        res_o
);

  logic [MAG_W:0] sum;
  logic [MAG_W:0] d_minus_s;
  logic [MAG_W:0] s_minus_d;

  // Both the sum and the two differences are formed side by side.
  assign sum       = {1'b0, dest_mag_i} + {1'b0, src_mag_i};
  assign d_minus_s = {1'b0, dest_mag_i} - {1'b0, src_mag_i};
  assign s_minus_d = {1'b0, src_mag_i} - {1'b0, dest_mag_i};

  // Like signs add; unlike signs subtract the smaller magnitude. An exact
  // zero keeps the first operand's sign.
  always_comb begin
    res_o.bad = 1'b0;
    if (dest_sign_i == src_sign_i) begin
      res_o.sign = dest_sign_i;
      res_o.mag  = sum[MAG_W-1:0];
      res_o.ov   = sum[MAG_W];
    end else if (d_minus_s[MAG_W]) begin
      res_o.sign = src_sign_i;
      res_o.mag  = s_minus_d[MAG_W-1:0];
      res_o.ov   = 1'b0;
    end else begin
      res_o.sign = dest_sign_i;
      res_o.mag  = d_minus_s[MAG_W-1:0];
      res_o.ov   = 1'b0;
    end
  end

endmodule

>>> tb/tb_mix_word_field_alu_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Word field ALU testbench
// Drives merge, add, negate and pass-through commands into the word field
// ALU and checks every result word against a predictor that runs alongside
// it. Directed cases cover the field and sign corner cases. Random
// commands follow, with random gaps on the command side and random stalls on
// the result side, and one long result stall that backs up the command side.
// ---------------------------------------------------------------------------
module tb_mix_word_field_alu_unit import mwfa_pkg::*; ();

  localparam int unsigned CLK_HALF_NS = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS = 5000000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [MAG_W-1:0] MAG_ONES = '1;
  localparam logic [MAG_W-1:0] DEST_PAT = {6'd11, 6'd12, 6'd13, 6'd14, 6'd15};
  localparam logic [MAG_W-1:0] SRC_PAT = {6'd41, 6'd42, 6'd43, 6'd44, 6'd45};

  logic clk;
  logic rst_n;

  mwfa_in_if  cmd_if ();
  mwfa_out_if res_if ();

  mix_word_field_alu_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Result words still owed by the block, oldest first.
  out_item_t expected_words[$];
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned op_seen[4];
  bit src_gaps_on;
  bit long_hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
  end
  always #(CLK_HALF_NS) clk = ~clk;

  // Watchdog for a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // Gap length: mostly none, sometimes short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Expected result word for one command.
  function automatic out_item_t predict_word(input in_item_t c);
    out_item_t        w;
    logic [MAG_W-1:0] mag;
    logic             sgn;
    logic             ovf;
    logic             bad;
    int               lo;
    int               hi;
    longint           a;
    longint           b;
    longint           s;
    longint unsigned  abs_s;
    mag = c.dest_mag;
    sgn = c.dest_sign;
    ovf = c.dest_ov;
    bad = 1'b0;
    lo  = int'(c.field_left);
    hi  = int'(c.field_right);
    case (cmd_e'(c.command))
      CMD_MERGE: begin
        // A zero left index takes the sign from the source, even in a bad field.
        sgn = c.clear_sign ? 1'b0 : c.dest_sign;
        if (lo == 0) begin
          sgn = c.src_sign;
        end
        ovf = c.dest_ov | c.src_ov;
        if (lo > MAX_FIELD || hi > MAX_FIELD) begin
          bad = 1'b1;
        end else begin
          if (lo == 0) begin
            lo = 1;
          end
          // An empty field leaves the loop without a pass.
          for (int k = lo; k <= hi; k++) begin
            if (c.align_from_source) begin
              mag[BYTE_W*(NUM_BYTES-k) +: BYTE_W] = c.src_mag[BYTE_W*(hi-k) +: BYTE_W];
            end else if (c.align_to_dest_right) begin
              mag[BYTE_W*(hi-k) +: BYTE_W] = c.src_mag[BYTE_W*(NUM_BYTES-k) +: BYTE_W];
            end else begin
              mag[BYTE_W*(NUM_BYTES-k) +: BYTE_W] = c.src_mag[BYTE_W*(NUM_BYTES-k) +: BYTE_W];
            end
          end
        end
      end
      CMD_ADD: begin
        // Exact signed sum; a zero sum keeps the first operand's sign.
        a = longint'(c.dest_mag);
        b = longint'(c.src_mag);
        if (c.dest_sign) begin
          a = -a;
        end
        if (c.src_sign) begin
          b = -b;
        end
        s = a + b;
        if (s < 0) begin
          sgn   = 1'b1;
          abs_s = -s;
        end else begin
          sgn   = 1'b0;
          abs_s = s;
        end
        if (s == 0) begin
          sgn = c.dest_sign;
        end
        mag = abs_s[MAG_W-1:0];
        ovf = (abs_s >> MAG_W) != 0;
      end
      CMD_NEGATE: begin
        sgn = ~c.dest_sign;
      end
      default: begin
      end
    endcase
    w.result_sign    = sgn;
    w.result_mag     = mag;
    w.result_ov      = ovf;
    w.index_overflow = ovf | (|mag[MAG_W-1:INDEX_LSB]);
    w.bad_field      = bad;
    return w;
  endfunction

  // Result side: ready spells and stalls of random length, or one long hold.
  logic        sink_state;
  int unsigned sink_left;

  initial begin
    sink_state    = 1'b0;
    sink_left     = 0;
    long_hold_req = 1'b0;
  end

  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      sink_state    = 1'b0;
      sink_left     = LONG_HOLD;
    end else if (sink_left == 0) begin
      sink_state = ~sink_state;
      sink_left  = sink_state ? $urandom_range(1, 24) : pick_gap() + 1;
    end
    sink_left--;
    res_if.ready <= sink_state;
  end

  // Record each command transfer first, then check each result transfer.
  always @(posedge clk) begin : scoreboard
    in_item_t  c;
    out_item_t got;
    out_item_t want;
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) begin
        c.command             = cmd_if.command;
        c.dest_sign           = cmd_if.dest_sign;
        c.dest_mag            = cmd_if.dest_mag;
        c.dest_ov             = cmd_if.dest_ov;
        c.src_sign            = cmd_if.src_sign;
        c.src_mag             = cmd_if.src_mag;
        c.src_ov              = cmd_if.src_ov;
        c.field_left          = cmd_if.field_left;
        c.field_right         = cmd_if.field_right;
        c.clear_sign          = cmd_if.clear_sign;
        c.align_from_source   = cmd_if.align_from_source;
        c.align_to_dest_right = cmd_if.align_to_dest_right;
        expected_words.push_back(predict_word(c));
        op_seen[c.command]++;
      end
      if (res_if.valid && res_if.ready) begin
        got.result_sign    = res_if.result_sign;
        got.result_mag     = res_if.result_mag;
        got.result_ov      = res_if.result_ov;
        got.index_overflow = res_if.index_overflow;
        got.bad_field      = res_if.bad_field;
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Unexpected result at %0t: sign=%0b mag=%08h ov=%0b idx=%0b bad=%0b",
                     $realtime, got.result_sign, got.result_mag, got.result_ov,
                     got.index_overflow, got.bad_field);
          end
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (got.result_sign !== want.result_sign || got.result_mag !== want.result_mag ||
              got.result_ov !== want.result_ov ||
              got.index_overflow !== want.index_overflow ||
              got.bad_field !== want.bad_field) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("Mismatch at %0t, result %0d:", $realtime, results_checked);
              $display("  expected sign=%0b mag=%08h ov=%0b idx=%0b bad=%0b",
                       want.result_sign, want.result_mag, want.result_ov,
                       want.index_overflow, want.bad_field);
              $display("  actual   sign=%0b mag=%08h ov=%0b idx=%0b bad=%0b",
                       got.result_sign, got.result_mag, got.result_ov,
                       got.index_overflow, got.bad_field);
            end
          end
        end
      end
    end
  end

  // Offer one command after a random gap and wait for its transfer.
  task automatic send_cmd(input in_item_t item);
    int unsigned gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid               <= 1'b1;
    cmd_if.command             <= item.command;
    cmd_if.dest_sign           <= item.dest_sign;
    cmd_if.dest_mag            <= item.dest_mag;
    cmd_if.dest_ov             <= item.dest_ov;
    cmd_if.src_sign            <= item.src_sign;
    cmd_if.src_mag             <= item.src_mag;
    cmd_if.src_ov              <= item.src_ov;
    cmd_if.field_left          <= item.field_left;
    cmd_if.field_right         <= item.field_right;
    cmd_if.clear_sign          <= item.clear_sign;
    cmd_if.align_from_source   <= item.align_from_source;
    cmd_if.align_to_dest_right <= item.align_to_dest_right;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
  endtask

  // Stop offering commands.
  task automatic release_cmd();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_cmd(input cmd_e op, input bit dsg,
                                        input logic [MAG_W-1:0] dmag, input bit dov,
                                        input bit ssg, input logic [MAG_W-1:0] smag,
                                        input bit sov, input int left, input int right,
                                        input bit dpos, input bit from_src,
                                        input bit to_right);
    in_item_t c;
    c.command             = op;
    c.dest_sign           = dsg;
    c.dest_mag            = dmag;
    c.dest_ov             = dov;
    c.src_sign            = ssg;
    c.src_mag             = smag;
    c.src_ov              = sov;
    c.field_left          = FIELD_W'(left);
    c.field_right         = FIELD_W'(right);
    c.clear_sign          = dpos;
    c.align_from_source   = from_src;
    c.align_to_dest_right = to_right;
    return c;
  endfunction

  // Magnitudes: some extremes, many small enough to clear the index flag.
  function automatic logic [MAG_W-1:0] rand_mag();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return '0;
    end else if (roll < 10) begin
      return MAG_ONES;
    end else if (roll < 35) begin
      return MAG_W'($urandom_range(0, 4095));
    end
    return MAG_W'($urandom());
  endfunction

  // Random command; mostly well-formed fields, any fields when any_field is set.
  function automatic in_item_t rand_cmd(input cmd_e op, input bit any_field);
    in_item_t c;
    int       left;
    int       right;
    if (any_field || $urandom_range(0, 99) < 15) begin
      left  = $urandom_range(0, 7);
      right = $urandom_range(0, 7);
    end else begin
      left  = $urandom_range(0, NUM_BYTES);
      right = $urandom_range(left, NUM_BYTES);
    end
    c = make_cmd(op, 1'($urandom_range(0, 1)), rand_mag(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), rand_mag(), 1'($urandom_range(0, 1)), left,
                 right, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    return c;
  endfunction

  // Field merge corner cases: sign field, alignments, empty and bad fields.
  task automatic test_merge_directed();
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 0, 0, SRC_PAT, 0, 0, 5, 0, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 1, 0, SRC_PAT, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 0, DEST_PAT, 0, 1, SRC_PAT, 1, 1, 5, 0, 1, 0));
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 0, 1, SRC_PAT, 0, 2, 3, 0, 1, 0));
    send_cmd(make_cmd(CMD_MERGE, 0, DEST_PAT, 0, 0, SRC_PAT, 0, 2, 4, 0, 0, 1));
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 0, 0, SRC_PAT, 0, 1, 3, 1, 1, 1));
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 0, 1, SRC_PAT, 0, 4, 2, 0, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 0, 1, SRC_PAT, 1, 6, 3, 0, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 0, DEST_PAT, 1, 1, SRC_PAT, 0, 0, 7, 1, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 1, MAG_ONES, 1, 1, MAG_ONES, 1, 7, 7, 1, 1, 1));
    send_cmd(make_cmd(CMD_MERGE, 0, '0, 0, 0, '0, 0, 5, 5, 0, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 1, DEST_PAT, 0, 0, SRC_PAT, 0, 0, 3, 1, 0, 0));
    send_cmd(make_cmd(CMD_MERGE, 1, '0, 0, 0, MAG_ONES, 0, 4, 5, 0, 0, 0));
    release_cmd();
  endtask

  // Add corner cases: carry out, exact wrap, zero sums of either sign.
  task automatic test_add_directed();
    send_cmd(make_cmd(CMD_ADD, 0, MAG_ONES, 0, 0, MAG_ONES, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 1, MAG_ONES, 0, 1, MAG_ONES, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 0, MAG_ONES, 1, 0, 30'd1, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 0, 30'd5, 0, 1, 30'd5, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 1, 30'd5, 0, 0, 30'd5, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 1, '0, 0, 0, '0, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD, 0, 30'd3, 1, 1, 30'd10, 1, 0, 0, 0, 0, 0));
    release_cmd();
  endtask

  // Negate and the unused command that passes the destination through.
  task automatic test_negate_pass_directed();
    send_cmd(make_cmd(CMD_NEGATE, 0, DEST_PAT, 1, 1, SRC_PAT, 0, 6, 7, 1, 1, 1));
    send_cmd(make_cmd(CMD_NEGATE, 1, '0, 0, 0, MAG_ONES, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_PASS, 1, MAG_ONES, 1, 0, '0, 0, 7, 6, 1, 1, 1));
    send_cmd(make_cmd(CMD_PASS, 0, 30'd77, 0, 1, SRC_PAT, 1, 0, 0, 0, 0, 0));
    release_cmd();
  endtask

  task automatic test_random_merge(input int unsigned count);
    repeat (count) send_cmd(rand_cmd(CMD_MERGE, 1'b0));
    release_cmd();
  endtask

  // Random adds, with a share of operands that cancel exactly.
  task automatic test_random_add(input int unsigned count);
    in_item_t c;
    repeat (count) begin
      c = rand_cmd(CMD_ADD, 1'b1);
      if ($urandom_range(0, 9) == 0) begin
        c.src_mag  = c.dest_mag;
        c.src_sign = ~c.dest_sign;
      end
      send_cmd(c);
    end
    release_cmd();
  endtask

  // Every command code with fields fully random.
  task automatic test_random_mixed(input int unsigned count);
    repeat (count) send_cmd(rand_cmd(cmd_e'($urandom_range(0, 3)), 1'b1));
    release_cmd();
  endtask

  // Long result stall while commands keep coming back to back.
  task automatic test_backpressure(input int unsigned count);
    @(negedge clk);
    long_hold_req = 1'b1;
    @(posedge clk);
    src_gaps_on = 1'b0;
    repeat (count) send_cmd(rand_cmd(cmd_e'($urandom_range(0, 3)), 1'b0));
    src_gaps_on = 1'b1;
    release_cmd();
  endtask

  // Main sequence.
  initial begin : main_seq
    int unsigned waited;
    rst_n                      = 1'b0;
    src_gaps_on                = 1'b1;
    mismatch_count             = 0;
    results_checked            = 0;
    cmd_if.valid               = 1'b0;
    cmd_if.command             = CMD_MERGE;
    cmd_if.dest_sign           = 1'b0;
    cmd_if.dest_mag            = '0;
    cmd_if.dest_ov             = 1'b0;
    cmd_if.src_sign            = 1'b0;
    cmd_if.src_mag             = '0;
    cmd_if.src_ov              = 1'b0;
    cmd_if.field_left          = '0;
    cmd_if.field_right         = '0;
    cmd_if.clear_sign          = 1'b0;
    cmd_if.align_from_source   = 1'b0;
    cmd_if.align_to_dest_right = 1'b0;
    res_if.ready               = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_merge_directed();
    test_add_directed();
    test_negate_pass_directed();
    test_random_merge(180);
    test_random_add(120);
    test_backpressure(30);
    test_random_mixed(170);

    // Let every owed result arrive, then watch for strays.
    waited = 0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += expected_words.size();

    $display("Checked %0d results: %0d merges, %0d adds, %0d negates, %0d pass-throughs.",
             results_checked, op_seen[CMD_MERGE], op_seen[CMD_ADD], op_seen[CMD_NEGATE],
             op_seen[CMD_PASS]);
    $display("Covered sign and byte fields, both alignments, bad and empty fields, "
             , "add carry and zero sums, random stalls and a long output hold.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
